// ===== rtl/core/lpg_pkg.sv =====
package lpg_pkg;

    localparam int COORD_BITS = 9;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 16;

    typedef enum logic [0:0] {
        ACT_LOAD    = 1'b0,
        ACT_ADVANCE = 1'b1
    } lpg_action_t;

    typedef struct packed {
        lpg_action_t             action;
        logic [COORD_BITS-1:0]   start_x;
        logic [COORD_BITS-1:0]   start_y;
        logic [COORD_BITS-1:0]   end_x;
        logic [COORD_BITS-1:0]   end_y;
        logic [COLOR_BITS-1:0]   color;
    } lpg_cmd_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]   pixel_x;
        logic [COORD_BITS-1:0]   pixel_y;
        logic [COLOR_BITS-1:0]   pixel_color;
        logic                    last_pixel;
    } lpg_pixel_t;

    typedef struct packed {
        logic                       steep;
        logic [COORD_BITS-1:0]      major_pos;
        logic [COORD_BITS-1:0]      major_end;
        logic [COORD_BITS-1:0]      minor_pos;
        logic                       minor_down;
        logic signed [ERR_BITS-1:0] error_term;
        logic [COORD_BITS-1:0]      major_span;
        logic [COORD_BITS-1:0]      minor_span;
    } lpg_line_t;

endpackage

// ===== rtl/core/lpg_setup.sv =====
module lpg_setup (
    input  lpg_pkg::lpg_cmd_t  cmd,
    output lpg_pkg::lpg_line_t line
);
    import lpg_pkg::*;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  steep;
    logic [COORD_BITS-1:0] a_major;
    logic [COORD_BITS-1:0] a_minor;
    logic [COORD_BITS-1:0] b_major;
    logic [COORD_BITS-1:0] b_minor;
    logic                  swap;
    logic [COORD_BITS-1:0] lo_major;
    logic [COORD_BITS-1:0] hi_major;
    logic [COORD_BITS-1:0] lo_minor;
    logic [COORD_BITS-1:0] hi_minor;
    logic [COORD_BITS-1:0] span;

    always_comb
    begin
        dx = (cmd.end_x > cmd.start_x) ? (cmd.end_x - cmd.start_x) : (cmd.start_x - cmd.end_x);
        dy = (cmd.end_y > cmd.start_y) ? (cmd.end_y - cmd.start_y) : (cmd.start_y - cmd.end_y);
        steep = dy > dx;

        // swap axes for steep lines
        a_major = steep ? cmd.start_y : cmd.start_x;
        a_minor = steep ? cmd.start_x : cmd.start_y;
        b_major = steep ? cmd.end_y   : cmd.end_x;
        b_minor = steep ? cmd.end_x   : cmd.end_y;

        // order endpoints so the major coordinate rises
        swap     = a_major > b_major;
        lo_major = swap ? b_major : a_major;
        hi_major = swap ? a_major : b_major;
        lo_minor = swap ? b_minor : a_minor;
        hi_minor = swap ? a_minor : b_minor;

        span = hi_major - lo_major;

        line.steep      = steep;
        line.major_pos  = lo_major;
        line.major_end  = hi_major;
        line.minor_pos  = lo_minor;
        line.minor_down = !(lo_minor < hi_minor);
        line.major_span = span;
        line.minor_span = (hi_minor > lo_minor) ? (hi_minor - lo_minor) : (lo_minor - hi_minor);
        line.error_term = -$signed({2'b00, (span >> 1)});
    end

endmodule

// ===== rtl/core/line_pixel_generator.sv =====
// Bresenham line rasterizer. A load transaction (action 0) sets up a line from two
// endpoints and a color and produces no pixel; each advance transaction (action 1)
// produces the next pixel of the line, with last_pixel set on the final one, after
// which advances are dropped until the next load. A load during a line restarts it.
// One command transaction can be taken every clock cycle while cmd_ready is high: the
// error and minor-axis update is a single add, compare and subtract done in the cycle of
// acceptance, and the pixel is registered into the output stage. A two-entry output
// stage holds pixels while the output is stalled; cmd_ready drops only when both entries
// are full, and rises again the cycle after one is taken.
module line_pixel_generator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  lpg_pkg::lpg_cmd_t   cmd,
    output logic                pixel_valid,
    input  logic                pixel_ready,
    output lpg_pkg::lpg_pixel_t pixel
);
    import lpg_pkg::*;

    lpg_line_t             setup_line;
    lpg_line_t             line_reg;
    lpg_line_t             line_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [COLOR_BITS-1:0] color_reg;
    logic [COLOR_BITS-1:0] color_next;

    logic                  out_valid_reg;
    lpg_pixel_t            out_reg;
    logic                  skid_valid_reg;
    lpg_pixel_t            skid_reg;

    logic                  cmd_fire;
    logic                  pix_pop;
    logic                  emit;
    logic                  last;
    lpg_pixel_t            new_pix;
    logic signed [ERR_BITS-1:0] err_sum;

    lpg_setup u_setup (
        .cmd  (cmd),
        .line (setup_line)
    );

    assign cmd_ready   = !skid_valid_reg;
    assign cmd_fire    = cmd_valid && cmd_ready;
    assign pix_pop     = out_valid_reg && pixel_ready;
    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    assign last    = line_reg.major_pos == line_reg.major_end;
    assign err_sum = line_reg.error_term + $signed({2'b00, line_reg.minor_span});

    always_comb
    begin
        new_pix.pixel_x     = line_reg.steep ? line_reg.minor_pos : line_reg.major_pos;
        new_pix.pixel_y     = line_reg.steep ? line_reg.major_pos : line_reg.minor_pos;
        new_pix.pixel_color = color_reg;
        new_pix.last_pixel  = last;
    end

    // line state update
    always_comb
    begin
        line_next  = line_reg;
        busy_next  = busy_reg;
        color_next = color_reg;
        emit       = 1'b0;
        if (cmd_fire)
        begin
            unique case (cmd.action)
                ACT_LOAD:
                begin
                    line_next  = setup_line;
                    color_next = cmd.color;
                    busy_next  = 1'b1;
                end
                ACT_ADVANCE:
                begin
                    if (busy_reg)
                    begin
                        emit = 1'b1;
                        line_next.error_term = err_sum;
                        if (err_sum > 0)
                        begin
                            line_next.minor_pos = line_reg.minor_down
                                ? line_reg.minor_pos - 1'b1
                                : line_reg.minor_pos + 1'b1;
                            line_next.error_term = err_sum - $signed({2'b00, line_reg.major_span});
                        end
                        line_next.major_pos = line_reg.major_pos + 1'b1;
                        if (last)
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            line_reg  <= '0;
            color_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            line_reg  <= line_next;
            color_reg <= color_next;
        end
    end

    // two-entry output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pix_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (emit)
        begin
            if (out_valid_reg && !pix_pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pix_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pix_pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (emit)
        begin
            if (out_valid_reg && !pix_pop)
            begin
                skid_reg <= new_pix;
            end
            else
            begin
                out_reg <= new_pix;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (line_reg.major_pos <= line_reg.major_end))
        else $error("major position passed line end");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (line_reg.error_term >= -$signed({2'b00, line_reg.major_span})
                      && line_reg.error_term <= $signed({3'b000, line_reg.major_span[COORD_BITS-1:1]})))
        else $error("error term out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.action == ACT_ADVANCE && busy_reg && last) |=> !busy_reg)
        else $error("line still active after final pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.action == ACT_ADVANCE && !busy_reg) |=> $stable(out_valid_reg) || $past(pix_pop))
        else $error("pixel produced while idle");

endmodule
